// ===== rtl/core/connection_keepalive_watchdog_table_macros.svh =====
// Assertion helpers; expect clk and rst_n in scope.
`ifndef CONNECTION_KEEPALIVE_WATCHDOG_TABLE_MACROS_SVH
`define CONNECTION_KEEPALIVE_WATCHDOG_TABLE_MACROS_SVH

// same-cycle implication
`define CKWT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ckwt check failed");

// next-cycle implication
`define CKWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ckwt check failed");

`endif

// ===== rtl/core/ckwt_pkg.sv =====
package ckwt_pkg;

  localparam int SLOTS_DEF  = 8;
  localparam int MAX_EVENTS = 8;
  localparam int EV_CNT_W   = 4;

  localparam int FUNC_W     = 3;
  localparam int SLOT_IN_W  = 4;
  localparam int HANDLE_W   = 16;
  localparam int KIND_W     = 2;
  localparam int SLOT_OUT_W = 3;
  localparam int TICK_W     = 8;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd9;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_TIMEOUT = 1'b0;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ENTER = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LEAVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAN = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CMD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_CMD,
    ST_TRD,
    ST_TEV,
    ST_TEND
  } state_t;

  typedef struct packed {
    logic accept;
    logic alloc_step;
    logic cmd_step;
    logic tick_eval;
    logic tick_flush;
  } ctrl_t;

  typedef struct packed {
    logic [FUNC_W-1:0] req_func;
    logic              alloc_done;
    logic              cmd_done;
    logic              tev_hold;
    logic              idx_last;
    logic              flush_done;
    logic              pend_v;
  } status_t;

endpackage

// ===== rtl/core/ckwt_ifs.sv =====
interface ckwt_item_if;
  import ckwt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [SLOT_IN_W-1:0] slot;
  logic [HANDLE_W-1:0]  conn_handle;

  modport source (output valid, func, slot, conn_handle, input ready);
  modport sink (input valid, func, slot, conn_handle, output ready);
endinterface

interface ckwt_rslt_if;
  import ckwt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic                  ok;
  logic [SLOT_OUT_W-1:0] slot_out;
  logic [HANDLE_W-1:0]   handle_out;
  logic                  last;

  modport source (output valid, kind, ok, slot_out, handle_out, last, input ready);
  modport sink (input valid, kind, ok, slot_out, handle_out, last, output ready);
endinterface

// ===== rtl/core/connection_keepalive_watchdog_table.sv =====
// Keepalive watchdog table.
// in_bus: one beat per command (allocate, enter, leave, clean, tick) with
//   valid/ready; taken only while the table is idle.
// out_bus: result beats with valid/ready from an output register; last marks
//   the final beat of a command. Allocate and slot commands give one beat,
//   a tick gives zero to eight keepalive beats, lowest slot first.
// Slot commands answer from the output register once it is free. Allocate
//   walks slots from the top, one per cycle. A tick walks all slots, each
//   by a tick RAM read, then an update, and ends in a closing step. Its
//   events leave one beat behind the walk, the last one after the walk ends.
// Config: APB register 0 (timeout_ticks, 8 bits, reset 9); the user writes it
//   only while the table is idle, unchecked by the block. pready is always high.
// Reset: all slots free, event buffer and output register empty; handle and
//   tick RAMs need no clearing.
// Stall: a held output beat stops the walk at the next event; the output
//   register keeps its beat until out_bus.ready.
`include "connection_keepalive_watchdog_table_macros.svh"

module connection_keepalive_watchdog_table #(
  parameter int SLOTS = ckwt_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ckwt_item_if.sink                   in_bus,
  ckwt_rslt_if.source                 out_bus,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ckwt_pkg::CFG_AW-1:0] paddr,
  input  logic [ckwt_pkg::CFG_DW-1:0] pwdata,
  output logic [ckwt_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import ckwt_pkg::*;

  logic [TICK_W-1:0] timeout_r, timeout_nxt;
  logic              cfg_wr;
  ctrl_t             ctl;
  status_t           st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);

  always_comb begin
    timeout_nxt = cfg_wr ? pwdata[TICK_W-1:0] : timeout_r;
    prdata      = (paddr[2] == REG_TIMEOUT) ? CFG_DW'(timeout_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  ckwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .st       (st),
    .ctl      (ctl)
  );

  ckwt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .st         (st),
    .timeout    (timeout_r),
    .in_func    (in_bus.func),
    .in_slot    (in_bus.slot),
    .in_handle  (in_bus.conn_handle),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .out_kind   (out_bus.kind),
    .out_ok     (out_bus.ok),
    .out_slot   (out_bus.slot_out),
    .out_handle (out_bus.handle_out),
    .out_last   (out_bus.last)
  );

  `CKWT_ASSERT_NOW(a_single_beat_last, out_bus.valid && (out_bus.kind != KIND_EVENT), out_bus.last)
  `CKWT_ASSERT_NOW(a_idle_no_pending, in_bus.ready, !st.pend_v)
  `CKWT_ASSERT_NEXT(a_cmd_busy, in_bus.valid && in_bus.ready && (in_bus.func == FN_ALLOC || in_bus.func == FN_ENTER || in_bus.func == FN_LEAVE || in_bus.func == FN_CLEAN), !in_bus.ready)

endmodule

// ===== rtl/core/ckwt_ram.sv =====
module ckwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/ckwt_ctrl.sv =====
module ckwt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ckwt_pkg::status_t st,
  output ckwt_pkg::ctrl_t   ctl
);
  import ckwt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (st.req_func == FN_ALLOC) begin
            state_nxt = ST_ALLOC;
          end else if (st.req_func inside {FN_ENTER, FN_LEAVE, FN_CLEAN}) begin
            state_nxt = ST_CMD;
          end else if (st.req_func == FN_TICK) begin
            state_nxt = ST_TRD;
          end
        end
      end
      ST_ALLOC: begin
        if (st.alloc_done) state_nxt = ST_IDLE;
      end
      ST_CMD: begin
        if (st.cmd_done) state_nxt = ST_IDLE;
      end
      ST_TRD: begin
        state_nxt = ST_TEV;
      end
      ST_TEV: begin
        if (!st.tev_hold) state_nxt = st.idx_last ? ST_TEND : ST_TRD;
      end
      ST_TEND: begin
        if (st.flush_done) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      ST_ALLOC: begin
        ctl.alloc_step = 1'b1;
      end
      ST_CMD: begin
        ctl.cmd_step = 1'b1;
      end
      ST_TEV: begin
        ctl.tick_eval = 1'b1;
      end
      ST_TEND: begin
        ctl.tick_flush = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end
endmodule

// ===== rtl/core/ckwt_dp.sv =====
module ckwt_dp #(
  parameter int SLOTS = ckwt_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ckwt_pkg::ctrl_t                 ctl,
  output ckwt_pkg::status_t               st,
  input  logic [ckwt_pkg::TICK_W-1:0]     timeout,
  input  logic [ckwt_pkg::FUNC_W-1:0]     in_func,
  input  logic [ckwt_pkg::SLOT_IN_W-1:0]  in_slot,
  input  logic [ckwt_pkg::HANDLE_W-1:0]   in_handle,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ckwt_pkg::KIND_W-1:0]     out_kind,
  output logic                            out_ok,
  output logic [ckwt_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic [ckwt_pkg::HANDLE_W-1:0]   out_handle,
  output logic                            out_last
);
  import ckwt_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [FUNC_W-1:0]    func_r;
  logic [SLOT_IN_W-1:0] slot_r;
  logic [HANDLE_W-1:0]  hdl_r;

  // per-slot mode: free = !used, idle = used & !busy, busy = used & busy
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [SLOTS-1:0] hv_r, hv_nxt;

  logic [EV_CNT_W-1:0] evn_r, evn_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]    pend_slot_r, pend_slot_nxt;
  logic [HANDLE_W-1:0] pend_hdl_r, pend_hdl_nxt;

  logic                  out_v_r, out_v_nxt;
  logic [KIND_W-1:0]     out_kind_r, push_kind;
  logic                  out_ok_r, push_ok;
  logic [SLOT_OUT_W-1:0] out_slot_r, push_slot;
  logic [HANDLE_W-1:0]   out_hdl_r, push_hdl;
  logic                  out_last_r, push_last;
  logic                  push;

  logic                h_we, t_we;
  logic [IDX_W-1:0]    w_addr;
  logic [TICK_W-1:0]   t_wdata, t_rdata;
  logic [HANDLE_W-1:0] h_rdata;

  logic             out_free, in_range, cur_free, idx_zero, idx_last;
  logic             counted, below, due, tev_hold;
  logic [IDX_W-1:0] cmd_idx;

  ckwt_ram #(.WIDTH(HANDLE_W), .DEPTH(SLOTS)) u_hdl_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (w_addr),
    .wdata (hdl_r),
    .raddr (idx_r),
    .rdata (h_rdata)
  );

  ckwt_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_tick_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (w_addr),
    .wdata (t_wdata),
    .raddr (idx_r),
    .rdata (t_rdata)
  );

  assign out_free = !out_v_r || out_ready;
  assign in_range = (32'(slot_r) < SLOTS);
  assign cmd_idx  = IDX_W'(slot_r);
  assign cur_free = !used_r[idx_r];
  assign idx_zero = (idx_r == '0);
  assign idx_last = (idx_r == IDX_W'(SLOTS - 1));
  assign counted  = used_r[idx_r] && hv_r[idx_r];
  assign below    = (t_rdata < timeout);
  assign due      = counted && !below && !busy_r[idx_r]
                    && (evn_r < EV_CNT_W'(MAX_EVENTS));
  assign tev_hold = due && pend_v_r && !out_free;

  always_comb begin
    st            = '0;
    st.req_func   = in_func;
    st.alloc_done = out_free && (cur_free || idx_zero);
    st.cmd_done   = out_free;
    st.tev_hold   = tev_hold;
    st.idx_last   = idx_last;
    st.flush_done = !pend_v_r || out_free;
    st.pend_v     = pend_v_r;
  end

  always_comb begin
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    busy_nxt      = busy_r;
    hv_nxt        = hv_r;
    evn_nxt       = evn_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_hdl_nxt  = pend_hdl_r;
    push          = 1'b0;
    push_kind     = KIND_EVENT;
    push_ok       = 1'b1;
    push_slot     = SLOT_OUT_W'(pend_slot_r);
    push_hdl      = pend_hdl_r;
    push_last     = 1'b0;
    h_we          = 1'b0;
    t_we          = 1'b0;
    t_wdata       = '0;
    w_addr        = idx_r;

    if (ctl.accept) begin
      idx_nxt    = (in_func == FN_ALLOC) ? IDX_W'(SLOTS - 1) : '0;
      evn_nxt    = '0;
      pend_v_nxt = 1'b0;
    end

    if (ctl.alloc_step) begin
      if (cur_free) begin
        if (out_free) begin
          used_nxt[idx_r] = 1'b1;
          busy_nxt[idx_r] = 1'b0;
          hv_nxt[idx_r]   = 1'b1;
          h_we            = 1'b1;
          t_we            = 1'b1;
          push            = 1'b1;
          push_kind       = KIND_ALLOC;
          push_slot       = SLOT_OUT_W'(idx_r);
          push_hdl        = hdl_r;
          push_last       = 1'b1;
        end
      end else if (idx_zero) begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = KIND_ALLOC;
          push_ok   = 1'b0;
          push_slot = '0;
          push_hdl  = '0;
          push_last = 1'b1;
        end
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end

    if (ctl.cmd_step && out_free) begin
      push      = 1'b1;
      push_kind = KIND_CMD;
      push_ok   = in_range;
      push_slot = slot_r[SLOT_OUT_W-1:0];
      push_hdl  = '0;
      push_last = 1'b1;
      if (in_range) begin
        t_we   = 1'b1;
        w_addr = cmd_idx;
        case (func_r)
          FN_ENTER: begin
            used_nxt[cmd_idx] = 1'b1;
            busy_nxt[cmd_idx] = 1'b1;
          end
          FN_LEAVE: begin
            used_nxt[cmd_idx] = 1'b1;
            busy_nxt[cmd_idx] = 1'b0;
          end
          FN_CLEAN: begin
            used_nxt[cmd_idx] = 1'b0;
            busy_nxt[cmd_idx] = 1'b0;
            hv_nxt[cmd_idx]   = 1'b0;
          end
          default: begin
            t_we = 1'b0;
          end
        endcase
      end
    end

    if (ctl.tick_eval && !tev_hold) begin
      if (counted && below) begin
        t_we    = 1'b1;
        t_wdata = t_rdata + TICK_W'(1);
      end else if (due) begin
        // hold each event one beat so the scan end can flag the last one
        t_we          = 1'b1;
        push          = pend_v_r;
        pend_v_nxt    = 1'b1;
        pend_slot_nxt = idx_r;
        pend_hdl_nxt  = h_rdata;
        evn_nxt       = evn_r + 1'b1;
      end
      if (!idx_last) idx_nxt = idx_r + 1'b1;
    end

    if (ctl.tick_flush && pend_v_r && out_free) begin
      push       = 1'b1;
      push_last  = 1'b1;
      pend_v_nxt = 1'b0;
    end

    out_v_nxt = push || (out_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      used_r   <= '0;
      busy_r   <= '0;
      hv_r     <= '0;
      evn_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      used_r   <= used_nxt;
      busy_r   <= busy_nxt;
      hv_r     <= hv_nxt;
      evn_r    <= evn_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      func_r <= in_func;
      slot_r <= in_slot;
      hdl_r  <= in_handle;
    end
    pend_slot_r <= pend_slot_nxt;
    pend_hdl_r  <= pend_hdl_nxt;
    if (push) begin
      out_kind_r <= push_kind;
      out_ok_r   <= push_ok;
      out_slot_r <= push_slot;
      out_hdl_r  <= push_hdl;
      out_last_r <= push_last;
    end
  end

  assign out_valid  = out_v_r;
  assign out_kind   = out_kind_r;
  assign out_ok     = out_ok_r;
  assign out_slot   = out_slot_r;
  assign out_handle = out_hdl_r;
  assign out_last   = out_last_r;
endmodule
